>>> hw/rtl/rau_pkg.sv
// rational arithmetic unit package: command codes, widths, shared types
// no dependencies
package rau_pkg;
   localparam int WIDTH = 32;
   localparam int CNT_W = $clog2(WIDTH + 1);

   typedef logic [WIDTH-1:0] word_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [3:0] {
      CMD_ADD  = 4'd0,
      CMD_SUB  = 4'd1,
      CMD_MUL  = 4'd2,
      CMD_DIV  = 4'd3,
      CMD_NORM = 4'd4,
      CMD_INV  = 4'd5,
      CMD_GT   = 4'd6,
      CMD_LT   = 4'd7,
      CMD_EQ   = 4'd8
   } cmd_type;

   typedef struct packed {
      logic start;
      logic done;
   } hs_type;
endpackage

>>> hw/rtl/rau_mul.sv
// rational arithmetic unit: bit-serial shift-add multiplier, low WIDTH bits
// depends on rau_pkg
module rau_mul (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  rau_pkg::word_type x,
   input  rau_pkg::word_type y,
   output rau_pkg::word_type prod,
   output logic            done
);
   rau_pkg::word_type x_ff, x_in, y_ff, y_in, acc_ff, acc_in;
   rau_pkg::cnt_type  cnt_ff, cnt_in;
   logic              run_ff, run_in, done_ff, done_in;

   always_comb begin
      x_in = x_ff; y_in = y_ff; acc_in = acc_ff;
      cnt_in = cnt_ff; run_in = run_ff; done_in = 1'b0;
      if (start) begin
         x_in = x; y_in = y; acc_in = '0;
         cnt_in = rau_pkg::cnt_type'(rau_pkg::WIDTH); run_in = 1'b1;
      end else if (run_ff) begin
         if (y_ff[0]) acc_in = acc_ff + x_ff;
         x_in = x_ff << 1;
         y_in = y_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == rau_pkg::cnt_type'(1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; acc_ff <= acc_in; cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end

   assign prod = acc_ff;
   assign done = done_ff;
endmodule

>>> hw/rtl/rau_div.sv
// rational arithmetic unit: restoring bit-serial divider on magnitudes
// truncating signed quotient and remainder; depends on rau_pkg
module rau_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rau_pkg::word_type n,
   input  rau_pkg::word_type d,
   output rau_pkg::word_type quo,
   output rau_pkg::word_type rem,
   output logic              done
);
   localparam int W = rau_pkg::WIDTH;
   rau_pkg::word_type q_ff, q_in, d_ff, d_in;
   logic [W:0]        r_ff, r_in, diff;
   rau_pkg::cnt_type  cnt_ff, cnt_in;
   logic              qn_ff, qn_in, rn_ff, rn_in;
   logic              run_ff, run_in, done_ff, done_in;
   rau_pkg::word_type nm, dm;

   assign nm = n[W-1] ? -n : n;
   assign dm = d[W-1] ? -d : d;
   assign diff = {r_ff[W-1:0], q_ff[W-1]} - {1'b0, d_ff};

   always_comb begin
      q_in = q_ff; d_in = d_ff; r_in = r_ff; cnt_in = cnt_ff;
      qn_in = qn_ff; rn_in = rn_ff; run_in = run_ff; done_in = 1'b0;
      if (start) begin
         q_in = nm; d_in = dm; r_in = '0;
         qn_in = n[W-1] ^ d[W-1]; rn_in = n[W-1];
         cnt_in = rau_pkg::cnt_type'(W); run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[W]) begin
            r_in = diff;
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[W-1:0], q_ff[W-1]};
            q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == rau_pkg::cnt_type'(1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; d_ff <= d_in; r_ff <= r_in; cnt_ff <= cnt_in;
      qn_ff <= qn_in; rn_ff <= rn_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end

   assign quo  = qn_ff ? -q_ff : q_ff;
   assign rem  = rn_ff ? -r_ff[W-1:0] : r_ff[W-1:0];
   assign done = done_ff;
endmodule

>>> hw/rtl/rational_arithmetic_unit.sv
// rational arithmetic unit top level: sequencer over one serial multiplier
// and one serial divider; depends on rau_pkg, rau_mul, rau_div
//
//  channel | ports                                  | handshake
//  request | req_command req_a_num/a_den/b_num/b_den | start & !busy
//  result  | rsp_res_num rsp_res_den rsp_compare_true rsp_gcd_zero_error | rsp_valid, 1 cycle
//
// each product runs on the shared multiplier; add, sub and mul
// use three products, div and compare two, invert and unused codes none
// normalize runs Euclid one remainder step at a time on the divider, then two
// divides by the gcd, or flags gcd_zero_error if it is zero; S_OUT drives the result
// reset clears the sequencer; the result is shown for one cycle, no stall
module rational_arithmetic_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_command,
   input  logic signed [31:0] req_a_num,
   input  logic signed [31:0] req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic signed [31:0] req_b_den,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_res_num,
   output logic signed [31:0] rsp_res_den,
   output logic        rsp_compare_true,
   output logic        rsp_gcd_zero_error
);
   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_M0   = 8'b00000010,
      S_M1   = 8'b00000100,
      S_M2   = 8'b00001000,
      S_GCD  = 8'b00010000,
      S_Q0   = 8'b00100000,
      S_Q1   = 8'b01000000,
      S_OUT  = 8'b10000000
   } state_type;

   state_type st_ff, st_in;
   logic [3:0] cmd_ff, cmd_in;
   rau_pkg::word_type an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   rau_pkg::word_type p0_ff, p0_in, ga_ff, ga_in, gb_ff, gb_in;
   rau_pkg::word_type rn_ff, rn_in, rd_ff, rd_in;
   logic cmp_ff, cmp_in, err_ff, err_in, vld_ff, vld_in;
   logic launch_ff, launch_in;
   logic gw_ff, gw_in;

   rau_pkg::hs_type mhs, dhs;
   rau_pkg::word_type mx, my, prod, dn, dd, quo, rem;
   logic accept;

   assign accept = start && !busy;
   assign mhs.start = launch_ff && (st_ff == S_M0 || st_ff == S_M1 || st_ff == S_M2);
   assign dhs.start = launch_ff && (st_ff == S_GCD || st_ff == S_Q0 || st_ff == S_Q1);

   rau_mul u_mul (.clock(clock), .reset(reset), .start(mhs.start), .x(mx), .y(my),
                  .prod(prod), .done(mhs.done));
   rau_div u_div (.clock(clock), .reset(reset), .start(dhs.start), .n(dn), .d(dd),
                  .quo(quo), .rem(rem), .done(dhs.done));

   always_comb begin
      mx = an_ff; my = bd_ff;
      case (st_ff)
         S_M1: begin
            if (cmd_ff == rau_pkg::CMD_MUL) begin
               mx = an_ff; my = bn_ff;
            end else begin
               mx = ad_ff; my = bn_ff;
            end
         end
         S_M2: begin mx = ad_ff; my = bd_ff; end
         default: begin mx = an_ff; my = bd_ff; end
      endcase
      dn = gb_ff; dd = ga_ff;
      case (st_ff)
         S_Q0: begin dn = an_ff; dd = gb_ff; end
         S_Q1: begin dn = ad_ff; dd = gb_ff; end
         default: begin dn = gb_ff; dd = ga_ff; end
      endcase
   end

   always_comb begin
      st_in = st_ff; cmd_in = cmd_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      p0_in = p0_ff; ga_in = ga_ff; gb_in = gb_ff;
      rn_in = rn_ff; rd_in = rd_ff; cmp_in = cmp_ff; err_in = err_ff;
      vld_in = 1'b0; launch_in = 1'b0; gw_in = gw_ff;
      case (st_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_command;
               an_in = rau_pkg::word_type'(req_a_num);
               ad_in = rau_pkg::word_type'(req_a_den);
               bn_in = rau_pkg::word_type'(req_b_num);
               bd_in = rau_pkg::word_type'(req_b_den);
               rn_in = '0; rd_in = '0; cmp_in = 1'b0; err_in = 1'b0;
               launch_in = 1'b1;
               case (req_command)
                  rau_pkg::CMD_ADD, rau_pkg::CMD_SUB, rau_pkg::CMD_MUL, rau_pkg::CMD_DIV,
                  rau_pkg::CMD_GT, rau_pkg::CMD_LT, rau_pkg::CMD_EQ: st_in = S_M0;
                  rau_pkg::CMD_NORM: begin
                     ga_in = rau_pkg::word_type'(req_a_num);
                     gb_in = rau_pkg::word_type'(req_a_den);
                     st_in = S_GCD;
                     launch_in = 1'b0;
                  end
                  rau_pkg::CMD_INV: begin
                     rn_in = rau_pkg::word_type'(req_a_den);
                     rd_in = rau_pkg::word_type'(req_a_num);
                     st_in = S_OUT; launch_in = 1'b0;
                  end
                  default: begin st_in = S_OUT; launch_in = 1'b0; end
               endcase
            end
         end
         S_M0: begin
            if (mhs.done) begin
               p0_in = prod;
               launch_in = 1'b1;
               st_in = S_M1;
            end
         end
         S_M1: begin
            if (mhs.done) begin
               case (cmd_ff)
                  rau_pkg::CMD_ADD: begin
                     rn_in = p0_ff + prod; launch_in = 1'b1; st_in = S_M2;
                  end
                  rau_pkg::CMD_SUB: begin
                     rn_in = p0_ff - prod; launch_in = 1'b1; st_in = S_M2;
                  end
                  rau_pkg::CMD_MUL: begin
                     rn_in = prod; launch_in = 1'b1; st_in = S_M2;
                  end
                  rau_pkg::CMD_DIV: begin
                     rn_in = p0_ff; rd_in = prod; st_in = S_OUT;
                  end
                  rau_pkg::CMD_GT: begin
                     cmp_in = $signed(prod) < $signed(p0_ff); st_in = S_OUT;
                  end
                  rau_pkg::CMD_LT: begin
                     cmp_in = $signed(p0_ff) < $signed(prod); st_in = S_OUT;
                  end
                  default: begin
                     cmp_in = (p0_ff == prod); st_in = S_OUT;
                  end
               endcase
            end
         end
         S_M2: begin
            if (mhs.done) begin
               rd_in = prod; st_in = S_OUT;
            end
         end
         S_GCD: begin
            if (dhs.done) begin
               ga_in = rem; gb_in = ga_ff; gw_in = 1'b0;
            end else if (!gw_ff) begin
               if (ga_ff == '0) begin
                  if (gb_ff == '0) begin
                     err_in = 1'b1; st_in = S_OUT;
                  end else begin
                     launch_in = 1'b1; st_in = S_Q0;
                  end
               end else begin
                  launch_in = 1'b1; gw_in = 1'b1;
               end
            end
         end
         S_Q0: begin
            if (dhs.done) begin
               rn_in = quo; launch_in = 1'b1; st_in = S_Q1;
            end
         end
         S_Q1: begin
            if (dhs.done) begin
               rd_in = quo; st_in = S_OUT;
            end
         end
         S_OUT: begin
            vld_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      p0_ff <= p0_in; ga_ff <= ga_in; gb_ff <= gb_in;
      rn_ff <= rn_in; rd_ff <= rd_in; cmp_ff <= cmp_in; err_ff <= err_in;
      if (reset) begin
         st_ff <= S_IDLE; vld_ff <= 1'b0; launch_ff <= 1'b0; gw_ff <= 1'b0;
      end else begin
         st_ff <= st_in; vld_ff <= vld_in; launch_ff <= launch_in; gw_ff <= gw_in;
      end
   end

   assign busy = (st_ff != S_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_res_num = 32'(signed'(rn_ff));
   assign rsp_res_den = 32'(signed'(rd_ff));
   assign rsp_compare_true = cmp_ff;
   assign rsp_gcd_zero_error = err_ff;

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mhs.start && dhs.start)) else $error("both units launched");
   a_vld_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gcd_zero_error |-> rsp_res_num == 0 && rsp_res_den == 0)
      else $error("error with nonzero result");
endmodule

>>> tb/rational_arithmetic_unit_tb.sv
// testbench for rational_arithmetic_unit: directed and random fraction commands,
// results checked against an in-bench predictor of the rational arithmetic
// depends on rau_pkg and rational_arithmetic_unit
module rational_arithmetic_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] num;
      logic signed [31:0] den;
      logic               cmp;
      logic               err;
   } frac_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [3:0]  req_command = '0;
   logic signed [31:0] req_a_num = '0, req_a_den = '0, req_b_num = '0, req_b_den = '0;
   logic        rsp_valid;
   logic signed [31:0] rsp_res_num, rsp_res_den;
   logic        rsp_compare_true, rsp_gcd_zero_error;

   frac_result_type pending_results[$];
   int  mismatches = 0;
   bit  sender_idles = 1'b1;

   rational_arithmetic_unit i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic rau_pkg::word_type trunc_div(rau_pkg::word_type n,
                                                   rau_pkg::word_type d);
      rau_pkg::word_type q;
      q = (n[rau_pkg::WIDTH-1] ? -n : n) / (d[rau_pkg::WIDTH-1] ? -d : d);
      return (n[rau_pkg::WIDTH-1] != d[rau_pkg::WIDTH-1]) ? -q : q;
   endfunction

   function automatic rau_pkg::word_type trunc_rem(rau_pkg::word_type n,
                                                   rau_pkg::word_type d);
      rau_pkg::word_type r;
      r = (n[rau_pkg::WIDTH-1] ? -n : n) % (d[rau_pkg::WIDTH-1] ? -d : d);
      return n[rau_pkg::WIDTH-1] ? -r : r;
   endfunction

   function automatic frac_result_type rational_op(logic [3:0] cmd,
                                                   rau_pkg::word_type an,
                                                   rau_pkg::word_type ad,
                                                   rau_pkg::word_type bn,
                                                   rau_pkg::word_type bd);
      frac_result_type res;
      rau_pkg::word_type l, r, x, y, t;
      res = '{0, 0, 0, 0};
      l = an * bd;
      r = ad * bn;
      case (cmd)
         rau_pkg::CMD_ADD: begin res.num = l + bn * ad; res.den = ad * bd; end
         rau_pkg::CMD_SUB: begin res.num = l - bn * ad; res.den = ad * bd; end
         rau_pkg::CMD_MUL: begin res.num = an * bn; res.den = ad * bd; end
         rau_pkg::CMD_DIV: begin res.num = l; res.den = r; end
         rau_pkg::CMD_NORM: begin
            x = an;
            y = ad;
            while (x != 0) begin
               t = x;
               x = trunc_rem(y, x);
               y = t;
            end
            if (y == 0) res.err = 1'b1;
            else begin
               res.num = trunc_div(an, y);
               res.den = trunc_div(ad, y);
            end
         end
         rau_pkg::CMD_INV: begin res.num = ad; res.den = an; end
         rau_pkg::CMD_GT: res.cmp = $signed(l) > $signed(r);
         rau_pkg::CMD_LT: res.cmp = $signed(l) < $signed(r);
         rau_pkg::CMD_EQ: res.cmp = (l == r);
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatches++;
   endtask

   task automatic idle_burst();
      if (sender_idles && $urandom_range(3) == 0)
         repeat ($urandom_range(9, 1)) @(posedge clock);
   endtask

   task automatic send_item(logic [3:0] cmd, logic [31:0] an, logic [31:0] ad,
                            logic [31:0] bn, logic [31:0] bd);
      idle_burst();
      req_command <= cmd;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(rational_op(cmd, an, ad, bn, bd));
      start <= 1'b0;
      // the block is busy in the cycle after an accept
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      frac_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result item", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_res_num !== want.num) report_mismatch("res_num", rsp_res_num, want.num);
            if (rsp_res_den !== want.den) report_mismatch("res_den", rsp_res_den, want.den);
            if (rsp_compare_true !== want.cmp)
               report_mismatch("compare_true", rsp_compare_true, want.cmp);
            if (rsp_gcd_zero_error !== want.err)
               report_mismatch("gcd_zero_error", rsp_gcd_zero_error, want.err);
         end
      end
   end

   function automatic logic [31:0] rand_value();
      case ($urandom_range(5))
         0: return $urandom_range(20);
         1: return -$urandom_range(20);
         2: return 32'h8000_0000 + $urandom_range(2);
         3: return 32'h7fff_ffff - $urandom_range(2);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      logic [31:0] minv, maxv;
      minv = 32'h8000_0000;
      maxv = 32'h7fff_ffff;
      for (int c = rau_pkg::CMD_ADD; c <= rau_pkg::CMD_EQ; c++)
         send_item(4'(c), 3, 4, -5, 6);
      send_item(rau_pkg::CMD_NORM, 0, 0, 0, 0);
      send_item(rau_pkg::CMD_NORM, -12, 18, 0, 0);
      send_item(rau_pkg::CMD_NORM, 12, -18, 0, 0);
      send_item(rau_pkg::CMD_NORM, minv, -1, 0, 0);
      send_item(rau_pkg::CMD_NORM, minv, minv, 0, 0);
      send_item(rau_pkg::CMD_NORM, 0, 7, 0, 0);
      send_item(rau_pkg::CMD_ADD, maxv, 0, minv, 0);
      send_item(rau_pkg::CMD_MUL, minv, maxv, -1, -1);
      send_item(rau_pkg::CMD_GT, maxv, 1, minv, 1);
      send_item(rau_pkg::CMD_EQ, 0, 0, 0, 0);
      send_item(4'd9, 1, 2, 3, 4);
      send_item(4'd15, 32'hffff_ffff, minv, maxv, 32'hffff_ffff);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++)
         send_item(4'($urandom_range(9) == 0 ? $urandom_range(15, 9)
                                             : $urandom_range(rau_pkg::CMD_EQ)),
                   rand_value(), rand_value(), rand_value(), rand_value());
   endtask

   task automatic test_drain_pause();
      while (pending_results.size() != 0) @(posedge clock);
      send_item(rau_pkg::CMD_NORM, 100, 75, 0, 0);
   endtask

   initial begin
      int guard;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(400);
      test_drain_pause();
      test_random(300);
      sender_idles = 1'b0;
      test_random(120);
      guard = 0;
      while (pending_results.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #300ms;
      $display("tb: failure");
      $finish;
   end
endmodule
